// ===== sv/asst_pkg.sv =====
package asst_pkg;

   localparam int SIG_W      = 24;
   localparam int PROB_W     = 17;
   localparam int CNT_W      = 16;
   localparam int ACC_W      = 48;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [1:0] KIND_PROB  = 2'd0;
   localparam logic [1:0] KIND_EVENT = 2'd1;
   localparam logic [1:0] KIND_BATCH = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_STEP   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_MIN    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_MAX    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_RATE = 3'd4;

   localparam logic [CNT_W-1:0]         WINDOW_RESET    = 16'd100;
   localparam logic signed [SIG_W-1:0]  INIT_STEP_RESET = 24'sd0;
   localparam logic signed [SIG_W-1:0]  STEP_MIN_RESET  = -24'sd262144;
   localparam logic signed [SIG_W-1:0]  STEP_MAX_RESET  = 24'sd262144;
   localparam logic [PROB_W-1:0]        TARGET_RESET    = 17'd28836;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [PROB_W-1:0] accept_prob;
      logic              accepted;
      logic [CNT_W-1:0]  accepted_count;
   } req_payload_type;

   typedef struct packed {
      logic signed [SIG_W-1:0] log_step;
      logic                    adapted;
      logic [ACC_W-1:0]        prob_sum;
      logic [CNT_W-1:0]        sample_count;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_PROP_DIV,
      S_MUL,
      S_GAIN_START,
      S_GAIN_DIV,
      S_FINISH
   } state_type;

   typedef enum logic [1:0] {
      SRC_PROB,
      SRC_PROP,
      SRC_PROD
   } div_src_type;

   typedef struct packed {
      logic        capture;
      logic        div_start;
      div_src_type div_src;
      logic        mul_load;
      logic        commit;
   } cmd_type;

   typedef struct packed {
      logic is_prob;
      logic is_window;
      logic div_done;
   } status_type;

endpackage

// ===== sv/asst_div.sv =====
module asst_div #(
   parameter int DIV_W = 56,
   parameter int DVS_W = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic [DIV_W-1:0] quotient,
   output logic             done
);

   localparam int STEP_W = $clog2(DIV_W + 1);

   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [DVS_W:0]    rem_sh;
   logic [DVS_W:0]    diff;
   logic              ge;

   always_comb begin
      rem_sh = {rem_ff, quo_ff[DIV_W-1]};
      diff   = rem_sh - {1'b0, dvs_ff};
      ge     = rem_sh >= {1'b0, dvs_ff};
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
         cnt_in = STEP_W'(DIV_W);
      end else if (cnt_ff != '0) begin
         rem_in = ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff - STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = quo_ff;
   assign done     = (cnt_ff == '0);

endmodule

// ===== sv/asst_dp.sv =====
module asst_dp #(
   parameter int FRAC_BITS = 16,
   parameter int ITER_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  asst_pkg::req_payload_type             req_data,
   output asst_pkg::rsp_payload_type             rsp_data,
   input  logic                                  csr_we,
   input  logic [asst_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [asst_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  asst_pkg::cmd_type                     cmd,
   output asst_pkg::status_type                  status
);

   localparam int SIG_W  = asst_pkg::SIG_W;
   localparam int PROB_W = asst_pkg::PROB_W;
   localparam int CNT_W  = asst_pkg::CNT_W;
   localparam int ACC_W  = asst_pkg::ACC_W;
   localparam int PROP_W = CNT_W + FRAC_BITS;
   localparam int PROD_W = SIG_W + PROP_W;
   localparam int DIV_W  = PROD_W;
   localparam int DVS_W  = (ITER_BITS > CNT_W) ? ITER_BITS : CNT_W;
   localparam int SUM_W  = DIV_W + 2;

   logic [CNT_W-1:0]         window_ff;
   logic signed [SIG_W-1:0]  init_ff;
   logic signed [SIG_W-1:0]  min_ff;
   logic signed [SIG_W-1:0]  max_ff;
   logic [PROB_W-1:0]        target_ff;

   logic signed [SIG_W-1:0]  sigma_ff, sigma_in;
   logic [ITER_BITS-1:0]     iter_ff, iter_in;
   logic [CNT_W-1:0]         event_ff, event_in;
   logic [CNT_W-1:0]         tally_ff, tally_in;
   logic [ACC_W-1:0]         accum_ff, accum_in;

   asst_pkg::req_payload_type item_ff;
   asst_pkg::rsp_payload_type rsp_ff, rsp_in;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic                     neg_ff, neg_in;

   logic [1:0]               kind;
   logic [CNT_W-1:0]         ev_inc;
   logic [CNT_W-1:0]         tally_inc;
   logic [CNT_W-1:0]         w_eff;
   logic                     fire;
   logic                     adapted;
   logic                     prob_neg;
   logic [PROB_W-1:0]        prob_dmag;
   logic [CNT_W-1:0]         batch_cnt;
   logic [DIV_W-1:0]         dividend;
   logic [DVS_W-1:0]         divisor;
   logic [DIV_W-1:0]         quo;
   logic                     div_done;
   logic [PROP_W-1:0]        prop;
   logic [PROP_W-1:0]        target_ext;
   logic                     neg_d;
   logic [PROP_W-1:0]        dmag;
   logic [SIG_W-1:0]         gmag;
   logic [DIV_W-1:0]         mag;
   logic signed [SUM_W-1:0]  sig_ext;
   logic signed [SUM_W-1:0]  mag_ext;
   logic signed [SUM_W-1:0]  sum;
   logic signed [SUM_W-1:0]  max_ext;
   logic signed [SUM_W-1:0]  min_ext;
   logic signed [SIG_W-1:0]  sigma_new;
   logic [ACC_W-1:0]         p_ext;
   logic [ACC_W-1:0]         accum_sat;

   asst_div #(
      .DIV_W (DIV_W),
      .DVS_W (DVS_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .quotient (quo),
      .done     (div_done)
   );

   always_comb begin
      kind      = item_ff.req_type;
      ev_inc    = (event_ff != '1) ? event_ff + CNT_W'(1) : event_ff;
      tally_inc = (item_ff.accepted && tally_ff != '1) ? tally_ff + CNT_W'(1) : tally_ff;
      w_eff     = (window_ff == '0) ? CNT_W'(1) : window_ff;
      fire      = (kind == asst_pkg::KIND_EVENT) && (ev_inc >= w_eff);
      adapted   = (kind == asst_pkg::KIND_PROB) || (kind == asst_pkg::KIND_BATCH) || fire;

      status.is_prob   = (kind == asst_pkg::KIND_PROB);
      status.is_window = (kind == asst_pkg::KIND_BATCH) || fire;
      status.div_done  = div_done;

      prob_neg  = item_ff.accept_prob < target_ff;
      prob_dmag = prob_neg ? target_ff - item_ff.accept_prob
                           : item_ff.accept_prob - target_ff;
      batch_cnt = (kind == asst_pkg::KIND_BATCH) ? item_ff.accepted_count : tally_inc;

      case (cmd.div_src)
         asst_pkg::SRC_PROP: begin
            dividend = DIV_W'({batch_cnt, {FRAC_BITS{1'b0}}});
            divisor  = DVS_W'(w_eff);
         end
         asst_pkg::SRC_PROD: begin
            dividend = prod_ff;
            divisor  = DVS_W'(iter_ff);
         end
         default: begin
            dividend = DIV_W'(prob_dmag);
            divisor  = DVS_W'(iter_ff);
         end
      endcase

      prop       = quo[PROP_W-1:0];
      target_ext = PROP_W'(target_ff);
      neg_d      = prop < target_ext;
      dmag       = neg_d ? target_ext - prop : prop - target_ext;
      gmag       = init_ff[SIG_W-1] ? SIG_W'(~init_ff + SIG_W'(1)) : SIG_W'(init_ff);
      prod_in    = PROD_W'(gmag) * PROD_W'(dmag);

      neg_in = neg_ff;
      if (cmd.div_start && cmd.div_src == asst_pkg::SRC_PROB) begin
         neg_in = prob_neg;
      end else if (cmd.mul_load) begin
         neg_in = neg_d ^ init_ff[SIG_W-1];
      end

      mag     = (kind == asst_pkg::KIND_PROB) ? quo : (quo >> FRAC_BITS);
      sig_ext = {{(SUM_W-SIG_W){sigma_ff[SIG_W-1]}}, sigma_ff};
      mag_ext = {2'b00, mag};
      sum     = neg_ff ? sig_ext - mag_ext : sig_ext + mag_ext;
      max_ext = {{(SUM_W-SIG_W){max_ff[SIG_W-1]}}, max_ff};
      min_ext = {{(SUM_W-SIG_W){min_ff[SIG_W-1]}}, min_ff};
      if (sum > max_ext) begin
         sigma_new = max_ff;
      end else if (sum < min_ext) begin
         sigma_new = min_ff;
      end else begin
         sigma_new = sum[SIG_W-1:0];
      end

      p_ext     = ACC_W'(item_ff.accept_prob);
      accum_sat = (accum_ff > ({ACC_W{1'b1}} - p_ext)) ? {ACC_W{1'b1}} : accum_ff + p_ext;

      sigma_in = adapted ? sigma_new : sigma_ff;
      iter_in  = (adapted && iter_ff != '1) ? iter_ff + ITER_BITS'(1) : iter_ff;
      accum_in = accum_ff;
      event_in = event_ff;
      tally_in = tally_ff;
      case (kind)
         asst_pkg::KIND_PROB: begin
            accum_in = accum_sat;
            event_in = ev_inc;
         end
         asst_pkg::KIND_EVENT: begin
            event_in = fire ? '0 : ev_inc;
            tally_in = fire ? '0 : tally_inc;
         end
         default: begin
         end
      endcase

      rsp_in.log_step     = sigma_in;
      rsp_in.adapted      = adapted;
      rsp_in.prob_sum     = accum_in;
      rsp_in.sample_count = event_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= asst_pkg::WINDOW_RESET;
         init_ff   <= asst_pkg::INIT_STEP_RESET;
         min_ff    <= asst_pkg::STEP_MIN_RESET;
         max_ff    <= asst_pkg::STEP_MAX_RESET;
         target_ff <= asst_pkg::TARGET_RESET;
         sigma_ff  <= asst_pkg::INIT_STEP_RESET;
         iter_ff   <= ITER_BITS'(1);
         event_ff  <= '0;
         tally_ff  <= '0;
         accum_ff  <= '0;
      end else begin
         if (cmd.commit) begin
            sigma_ff <= sigma_in;
            iter_ff  <= iter_in;
            event_ff <= event_in;
            tally_ff <= tally_in;
            accum_ff <= accum_in;
         end
         if (csr_we) begin
            case (csr_index)
               asst_pkg::CSR_WINDOW_SIZE: window_ff <= csr_wdata[CNT_W-1:0];
               asst_pkg::CSR_INIT_STEP: begin
                  init_ff  <= csr_wdata[SIG_W-1:0];
                  sigma_ff <= csr_wdata[SIG_W-1:0];
               end
               asst_pkg::CSR_STEP_MIN:    min_ff    <= csr_wdata[SIG_W-1:0];
               asst_pkg::CSR_STEP_MAX:    max_ff    <= csr_wdata[SIG_W-1:0];
               asst_pkg::CSR_TARGET_RATE: target_ff <= csr_wdata[PROB_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_data;
      end
      if (cmd.mul_load) begin
         prod_ff <= prod_in;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
      neg_ff <= neg_in;
   end

   assign rsp_data = rsp_ff;

`ifndef SYNTHESIS
   a_iter_nonzero: assert property (@(posedge clock) disable iff (reset)
      iter_ff != '0)
      else $error("gain divisor reached zero");

   a_window_clear: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && fire) |=> (event_ff == '0) && (tally_ff == '0))
      else $error("window counters not cleared after window update");
`endif

endmodule

// ===== sv/asst_ctrl.sv =====
module asst_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  asst_pkg::status_type status,
   output asst_pkg::cmd_type    cmd
);

   asst_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         asst_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = asst_pkg::S_DECODE;
            end
         end
         asst_pkg::S_DECODE: begin
            if (status.is_prob) begin
               state_in = asst_pkg::S_GAIN_DIV;
            end else if (status.is_window) begin
               state_in = asst_pkg::S_PROP_DIV;
            end else begin
               state_in = asst_pkg::S_FINISH;
            end
         end
         asst_pkg::S_PROP_DIV: begin
            if (status.div_done) begin
               state_in = asst_pkg::S_MUL;
            end
         end
         asst_pkg::S_MUL:        state_in = asst_pkg::S_GAIN_START;
         asst_pkg::S_GAIN_START: state_in = asst_pkg::S_GAIN_DIV;
         asst_pkg::S_GAIN_DIV: begin
            if (status.div_done) begin
               state_in = asst_pkg::S_FINISH;
            end
         end
         asst_pkg::S_FINISH: begin
            if (out_free) begin
               state_in = asst_pkg::S_IDLE;
            end
         end
         default: state_in = asst_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      cmd.capture   = 1'b0;
      cmd.div_start = 1'b0;
      cmd.div_src   = asst_pkg::SRC_PROB;
      cmd.mul_load  = 1'b0;
      cmd.commit    = 1'b0;
      case (state_ff)
         asst_pkg::S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         asst_pkg::S_DECODE: begin
            if (status.is_prob) begin
               cmd.div_start = 1'b1;
               cmd.div_src   = asst_pkg::SRC_PROB;
            end else if (status.is_window) begin
               cmd.div_start = 1'b1;
               cmd.div_src   = asst_pkg::SRC_PROP;
            end
         end
         asst_pkg::S_MUL: cmd.mul_load = 1'b1;
         asst_pkg::S_GAIN_START: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = asst_pkg::SRC_PROD;
         end
         asst_pkg::S_FINISH: cmd.commit = out_free;
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= asst_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_div_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> !status.div_done)
      else $error("divider reports done right after start");

   a_commit_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before it was taken");

   a_commit_show: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff && (state_ff == asst_pkg::S_IDLE))
      else $error("committed item not presented");
`endif

endmodule

// ===== sv/adaptive_step_size_tuner.sv =====
// An event item with no window update needs no division, a probability item one division,
// and a window update two divisions with a multiply between them. One item at a time; the
// next item is accepted in the idle state entered when the result is registered. Divisions
// use the shared radix-2 divider, one quotient bit per cycle over 40 + FRAC_BITS bits.
// Synchronous active-high reset loads the register defaults, sets the log step to the
// initial value, the gain divisor to one and clears the counters.
module adaptive_step_size_tuner #(
   parameter int FRAC_BITS = 16,
   parameter int ITER_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  asst_pkg::req_payload_type         req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output asst_pkg::rsp_payload_type         rsp_data,
   input  logic                              csr_we,
   input  logic [asst_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [asst_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   asst_pkg::cmd_type    cmd;
   asst_pkg::status_type status;

   asst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   asst_dp #(
      .FRAC_BITS (FRAC_BITS),
      .ITER_BITS (ITER_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

// ===== tb/adaptive_step_size_tuner_tb.sv =====
`timescale 1ns / 1ps

module adaptive_step_size_tuner_tb;

   localparam int SIG_W      = asst_pkg::SIG_W;
   localparam int PROB_W     = asst_pkg::PROB_W;
   localparam int CNT_W      = asst_pkg::CNT_W;
   localparam int ACC_W      = asst_pkg::ACC_W;
   localparam int CSR_IDX_W  = asst_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = asst_pkg::CSR_DATA_W;
   localparam int FRAC = 16;
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam longint unsigned SUM_MAX = (64'd1 << ACC_W) - 1;
   localparam longint unsigned ITER_MAX = (64'd1 << 32) - 1;
   localparam longint unsigned COUNT_MAX = 65535;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int PHASES = 8;
   localparam int ITEMS_PER_PHASE = 120;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   asst_pkg::req_payload_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   asst_pkg::rsp_payload_type rsp_data;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   adaptive_step_size_tuner dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // tuner settings as seen by the predictor
   longint unsigned cfg_window;
   longint signed cfg_init_step;
   longint signed cfg_step_min;
   longint signed cfg_step_max;
   longint unsigned cfg_target;

   // predicted tuner state
   longint signed tuned_sigma;
   longint unsigned gain_divisor;
   longint unsigned event_total;
   longint unsigned accept_total;
   longint unsigned prob_total;

   asst_pkg::req_payload_type pending_items[$];
   asst_pkg::rsp_payload_type expected_steps[$];

   bit idle_on;
   int send_gap;
   int stall_left;
   int hold_left;
   bit long_hold_done;
   int unsigned kind_seen[4];
   int unsigned results_checked;
   int unsigned sigma_updates;
   int unsigned mismatches;
   int unsigned settings_run;
   int unsigned cycle_count;

   function automatic void nudge_sigma(longint signed delta);
      longint signed s;
      s = tuned_sigma + delta;
      if (s > cfg_step_max)
         s = cfg_step_max;
      else if (s < cfg_step_min)
         s = cfg_step_min;
      tuned_sigma = s;
      if (gain_divisor < ITER_MAX)
         gain_divisor++;
   endfunction

   function automatic void window_adapt(longint unsigned count);
      longint unsigned w, prop, dmag, gmag, mag;
      longint signed smag;
      bit neg_d, neg_g;
      w = (cfg_window == 0) ? 1 : cfg_window;
      prop = (count << FRAC) / w;
      neg_d = prop < cfg_target;
      dmag = neg_d ? cfg_target - prop : prop - cfg_target;
      neg_g = cfg_init_step < 0;
      gmag = neg_g ? -cfg_init_step : cfg_init_step;
      mag = ((gmag * dmag) / gain_divisor) >> FRAC;
      smag = mag;
      nudge_sigma((neg_d != neg_g) ? -smag : smag);
   endfunction

   function automatic asst_pkg::rsp_payload_type advance_tuner(asst_pkg::req_payload_type it);
      asst_pkg::rsp_payload_type r;
      longint unsigned p, w, mag;
      longint signed smag;
      logic changed;
      p = it.accept_prob;
      changed = 1'b0;
      case (it.req_type)
         asst_pkg::KIND_PROB: begin
            mag = (p < cfg_target) ? cfg_target - p : p - cfg_target;
            smag = mag / gain_divisor;
            nudge_sigma((p < cfg_target) ? -smag : smag);
            prob_total = (prob_total > SUM_MAX - p) ? SUM_MAX : prob_total + p;
            if (event_total < COUNT_MAX)
               event_total++;
            changed = 1'b1;
         end
         asst_pkg::KIND_EVENT: begin
            w = (cfg_window == 0) ? 1 : cfg_window;
            if (event_total < COUNT_MAX)
               event_total++;
            if (it.accepted && accept_total < COUNT_MAX)
               accept_total++;
            if (event_total >= w) begin
               window_adapt(accept_total);
               event_total = 0;
               accept_total = 0;
               changed = 1'b1;
            end
         end
         asst_pkg::KIND_BATCH: begin
            window_adapt(it.accepted_count);
            changed = 1'b1;
         end
         default: begin
         end
      endcase
      r.log_step = tuned_sigma[SIG_W-1:0];
      r.adapted = changed;
      r.prob_sum = prob_total[ACC_W-1:0];
      r.sample_count = event_total[CNT_W-1:0];
      return r;
   endfunction

   function automatic asst_pkg::req_payload_type make_item(logic [1:0] kind,
                                                           logic [PROB_W-1:0] p,
                                                           logic acc,
                                                           logic [CNT_W-1:0] cnt);
      asst_pkg::req_payload_type it;
      it.req_type = kind;
      it.accept_prob = p;
      it.accepted = acc;
      it.accepted_count = cnt;
      return it;
   endfunction

   function automatic asst_pkg::req_payload_type rand_item(logic [1:0] kind);
      asst_pkg::req_payload_type it;
      it.req_type = kind;
      it.accept_prob = ($urandom_range(0, 15) == 0) ? 17'd65536 :
                                                      PROB_W'($urandom_range(0, 65535));
      it.accepted = 1'($urandom_range(0, 1));
      it.accepted_count = CNT_W'($urandom_range(0, 65535));
      return it;
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         asst_pkg::CSR_WINDOW_SIZE: cfg_window = value[CNT_W-1:0];
         asst_pkg::CSR_INIT_STEP: begin
            cfg_init_step = $signed(value);
            tuned_sigma = cfg_init_step;
         end
         asst_pkg::CSR_STEP_MIN: cfg_step_min = $signed(value);
         asst_pkg::CSR_STEP_MAX: cfg_step_max = $signed(value);
         asst_pkg::CSR_TARGET_RATE: cfg_target = value[PROB_W-1:0];
         default: begin
         end
      endcase
   endtask

   task automatic drain();
      @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_steps.size() != 0)
         @(negedge clock);
   endtask

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_steps.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_steps.push_back(advance_tuner(req_data));
            kind_seen[req_data.req_type]++;
            if (idle_on && $urandom_range(0, 3) == 0)
               send_gap = $urandom_range(1, 17);
         end
         if (!req_valid || req_ready) begin
            if (send_gap != 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               req_valid <= 1'b1;
               req_data <= pending_items.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      asst_pkg::rsp_payload_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_steps.size() == 0) begin
               $error("result with no item pending: log_step %0d", rsp_data.log_step);
               mismatches++;
            end else begin
               want = expected_steps.pop_front();
               if (rsp_data.log_step !== want.log_step) begin
                  $error("log_step: expected %0d, got %0d", want.log_step, rsp_data.log_step);
                  mismatches++;
               end
               if (rsp_data.adapted !== want.adapted) begin
                  $error("adapted: expected %0d, got %0d", want.adapted, rsp_data.adapted);
                  mismatches++;
               end
               if (rsp_data.prob_sum !== want.prob_sum) begin
                  $error("prob_sum: expected %0d, got %0d", want.prob_sum, rsp_data.prob_sum);
                  mismatches++;
               end
               if (rsp_data.sample_count !== want.sample_count) begin
                  $error("sample_count: expected %0d, got %0d", want.sample_count,
                         rsp_data.sample_count);
                  mismatches++;
               end
               if (want.adapted)
                  sigma_updates++;
            end
            results_checked++;
         end
         if (!long_hold_done && results_checked >= 300) begin
            long_hold_done = 1'b1;
            hold_left = 600;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 7) == 0)
               stall_left = $urandom_range(1, 17);
         end
      end
   end

   initial begin : stimulus
      asst_pkg::req_payload_type it;
      logic signed [SIG_W-1:0] r24;
      longint signed lo, hi;
      int unsigned n, sel, w, run, odds, win;
      int phase;

      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      idle_on = 1'b1;
      send_gap = 0;
      stall_left = 0;
      hold_left = 0;
      long_hold_done = 1'b0;
      results_checked = 0;
      sigma_updates = 0;
      mismatches = 0;
      settings_run = 1;
      cycle_count = 0;
      foreach (kind_seen[i])
         kind_seen[i] = 0;

      cfg_window = asst_pkg::WINDOW_RESET;
      cfg_init_step = asst_pkg::INIT_STEP_RESET;
      cfg_step_min = asst_pkg::STEP_MIN_RESET;
      cfg_step_max = asst_pkg::STEP_MAX_RESET;
      cfg_target = asst_pkg::TARGET_RESET;
      tuned_sigma = asst_pkg::INIT_STEP_RESET;
      gain_divisor = 1;
      event_total = 0;
      accept_total = 0;
      prob_total = 0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: field extremes and every kind
      pending_items.push_back(make_item(asst_pkg::KIND_PROB, 17'd0, 1'b0, 16'd0));
      pending_items.push_back(make_item(asst_pkg::KIND_PROB, 17'd65536, 1'b1, 16'hFFFF));
      pending_items.push_back(make_item(asst_pkg::KIND_PROB, asst_pkg::TARGET_RESET, 1'b0,
                                        16'd0));
      pending_items.push_back(make_item(asst_pkg::KIND_EVENT, 17'd0, 1'b0, 16'd0));
      pending_items.push_back(make_item(asst_pkg::KIND_EVENT, 17'h1FFFF, 1'b1, 16'hFFFF));
      pending_items.push_back(make_item(asst_pkg::KIND_BATCH, 17'd0, 1'b0, 16'd0));
      pending_items.push_back(make_item(asst_pkg::KIND_BATCH, 17'd0, 1'b0, 16'hFFFF));
      pending_items.push_back(make_item(KIND_UNUSED, 17'h1FFFF, 1'b1, 16'hFFFF));
      pending_items.push_back(make_item(KIND_UNUSED, 17'd0, 1'b0, 16'd0));
      drain();

      // largest gain, widest clamps, zero target; count already past the window
      write_reg(asst_pkg::CSR_INIT_STEP, 24'h7FFFFF);
      write_reg(asst_pkg::CSR_WINDOW_SIZE, 24'd3);
      write_reg(asst_pkg::CSR_TARGET_RATE, 24'd0);
      write_reg(asst_pkg::CSR_STEP_MIN, 24'h800000);
      write_reg(asst_pkg::CSR_STEP_MAX, 24'h7FFFFF);
      settings_run++;
      pending_items.push_back(make_item(asst_pkg::KIND_EVENT, 17'd0, 1'b1, 16'd0));
      pending_items.push_back(make_item(asst_pkg::KIND_EVENT, 17'd0, 1'b1, 16'd0));
      pending_items.push_back(make_item(asst_pkg::KIND_EVENT, 17'd0, 1'b0, 16'd0));
      pending_items.push_back(make_item(asst_pkg::KIND_BATCH, 17'd0, 1'b0, 16'hFFFF));
      pending_items.push_back(make_item(asst_pkg::KIND_PROB, 17'd65536, 1'b0, 16'd0));
      drain();

      // most negative gain, full target, zero window
      write_reg(asst_pkg::CSR_INIT_STEP, 24'h800000);
      write_reg(asst_pkg::CSR_TARGET_RATE, 24'd65536);
      write_reg(asst_pkg::CSR_WINDOW_SIZE, 24'd0);
      write_reg(asst_pkg::CSR_STEP_MIN, asst_pkg::STEP_MIN_RESET);
      write_reg(asst_pkg::CSR_STEP_MAX, asst_pkg::STEP_MAX_RESET);
      settings_run++;
      pending_items.push_back(make_item(asst_pkg::KIND_EVENT, 17'd0, 1'b0, 16'd0));
      pending_items.push_back(make_item(asst_pkg::KIND_BATCH, 17'd0, 1'b0, 16'd0));
      pending_items.push_back(make_item(asst_pkg::KIND_PROB, 17'd0, 1'b0, 16'd0));
      pending_items.push_back(make_item(asst_pkg::KIND_PROB, 17'd65536, 1'b0, 16'd0));
      drain();

      // inverted clamp pair, then shrink the window below the count
      write_reg(asst_pkg::CSR_STEP_MIN, 24'd100000);
      write_reg(asst_pkg::CSR_STEP_MAX, -24'sd100000);
      write_reg(asst_pkg::CSR_WINDOW_SIZE, 24'd10);
      settings_run++;
      repeat (4)
         pending_items.push_back(rand_item(asst_pkg::KIND_PROB));
      pending_items.push_back(make_item(asst_pkg::KIND_EVENT, 17'd0, 1'b1, 16'd0));
      drain();
      write_reg(asst_pkg::CSR_WINDOW_SIZE, 24'd2);
      settings_run++;
      pending_items.push_back(make_item(asst_pkg::KIND_EVENT, 17'd0, 1'b1, 16'd0));
      drain();

      for (phase = 0; phase < PHASES; phase++) begin
         if (phase == PHASES - 1)
            idle_on = 1'b0;

         sel = $urandom_range(0, 99);
         if (sel < 60)
            win = $urandom_range(1, 12);
         else if (sel < 75)
            win = $urandom_range(13, 100);
         else if (sel < 85)
            win = 0;
         else if (sel < 95)
            win = 1;
         else
            win = 65535;
         write_reg(asst_pkg::CSR_WINDOW_SIZE, CSR_DATA_W'(win));

         sel = $urandom_range(0, 99);
         if (sel < 70) begin
            lo = -longint'($urandom_range(0, 1 << 20));
            hi = longint'($urandom_range(0, 1 << 20));
         end else if (sel < 80) begin
            lo = -(64'sd1 << 23);
            hi = (64'sd1 << 23) - 1;
         end else if (sel < 90) begin
            lo = longint'($urandom_range(0, 1 << 18));
            hi = -longint'($urandom_range(0, 1 << 18));
         end else begin
            r24 = SIG_W'($urandom);
            lo = longint'(r24);
            r24 = SIG_W'($urandom);
            hi = longint'(r24);
         end
         write_reg(asst_pkg::CSR_STEP_MIN, CSR_DATA_W'(lo));
         write_reg(asst_pkg::CSR_STEP_MAX, CSR_DATA_W'(hi));

         sel = $urandom_range(0, 99);
         write_reg(asst_pkg::CSR_TARGET_RATE,
                   CSR_DATA_W'((sel < 70) ? $urandom_range(0, 65536) :
                               (sel < 85) ? 0 : 65536));

         if ($urandom_range(0, 3) != 0) begin
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
               r24 = SIG_W'($urandom_range(0, 1 << 20));
               if ($urandom_range(0, 1))
                  r24 = -r24;
            end else if (sel < 85) begin
               r24 = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
            end else begin
               r24 = SIG_W'($urandom);
            end
            write_reg(asst_pkg::CSR_INIT_STEP, r24);
         end
         settings_run++;

         n = 0;
         while (n < ITEMS_PER_PHASE) begin
            sel = $urandom_range(0, 99);
            w = (cfg_window == 0) ? 1 : 32'(cfg_window);
            if (sel < 55) begin
               run = (w <= 24) ? w : $urandom_range(1, 24);
               odds = $urandom_range(0, 4);
               repeat (run) begin
                  it = rand_item(asst_pkg::KIND_EVENT);
                  it.accepted = ($urandom_range(0, 3) < odds);
                  pending_items.push_back(it);
               end
               n += run;
            end else begin
               if (sel < 80) begin
                  it = rand_item(asst_pkg::KIND_PROB);
               end else if (sel < 92) begin
                  it = rand_item(asst_pkg::KIND_BATCH);
                  if ($urandom_range(0, 9) < 7)
                     it.accepted_count = CNT_W'($urandom_range(0, (w > 65535) ? 65535 : w));
               end else if (sel < 96) begin
                  it = rand_item(KIND_UNUSED);
               end else begin
                  it = rand_item(asst_pkg::KIND_EVENT);
               end
               pending_items.push_back(it);
               n++;
            end
         end
         drain();
      end

      repeat (150) @(posedge clock);
      if (expected_steps.size() != 0) begin
         $error("%0d results never arrived", expected_steps.size());
         mismatches++;
      end
      $display("Ran %0d items under %0d settings: %0d probability, %0d event, %0d batch,",
               results_checked, settings_run, kind_seen[asst_pkg::KIND_PROB],
               kind_seen[asst_pkg::KIND_EVENT], kind_seen[asst_pkg::KIND_BATCH]);
      $display("%0d unused-kind items; %0d sigma updates checked, %0d mismatches",
               kind_seen[KIND_UNUSED], sigma_updates, mismatches);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/asst_pkg.sv
sv/asst_div.sv
sv/asst_dp.sv
sv/asst_ctrl.sv
sv/adaptive_step_size_tuner.sv
tb/adaptive_step_size_tuner_tb.sv
